@@ hw/rtl/address_hash_index_linear_probe_assert.svh @@
// Assertion macros used by the hash index top module.
`ifndef ADDRESS_HASH_INDEX_LINEAR_PROBE_ASSERT_SVH
`define ADDRESS_HASH_INDEX_LINEAR_PROBE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHILP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AHILP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ahilp_pkg.sv @@
package ahilp_pkg;

    // Default table depth
    localparam int DEF_TABLE_DEPTH = 16384;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 14;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 14;
    localparam int HASH_W   = 16;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

    // One table slot as held in memory
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [ENTRY_W-1:0] entry;
    } t_slot;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_PROBE,
        S_CLEAR
    } t_state;

endpackage

@@ hw/rtl/ahilp_mem.sv @@
module ahilp_mem #(
    parameter int TABLE_DEPTH = ahilp_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  ahilp_pkg::t_slot i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output ahilp_pkg::t_slot o_rd_data
);

    ahilp_pkg::t_slot mem [TABLE_DEPTH];
    ahilp_pkg::t_slot r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/ahilp_hash.sv @@
module ahilp_hash #(
    parameter int TABLE_DEPTH = ahilp_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ahilp_pkg::HASH_W-1:0] i_value,
    output logic                         o_done,
    output logic [AW-1:0]                o_home
);

    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic [AW-1:0] r_home;

            // Power-of-two depth: the remainder is the low bits
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_home <= i_value[AW-1:0];
                end
            end

            assign o_done = 1'b1;
            assign o_home = r_home;
        end else begin : g_recip
            // floor(v / depth) = (v * RECIP) >> SHIFT, exact for every 16-bit v
            localparam int SHIFT = ahilp_pkg::HASH_W + AW;
            localparam logic [ahilp_pkg::HASH_W:0] RECIP =
                (ahilp_pkg::HASH_W+1)'(((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1)
                                       / 64'(TABLE_DEPTH));
            localparam logic [ahilp_pkg::HASH_W-1:0] DEP = ahilp_pkg::HASH_W'(TABLE_DEPTH);
            localparam int PROD_W = 2 * ahilp_pkg::HASH_W + 1;

            logic [1:0]                   r_phase;
            logic [ahilp_pkg::HASH_W-1:0] r_val;
            logic [ahilp_pkg::HASH_W-1:0] r_quo;
            logic [AW-1:0]                r_rem;
            logic [PROD_W-1:0]            prod;
            logic [ahilp_pkg::HASH_W-1:0] back;

            // Stage one: quotient by reciprocal; stage two: value less quotient times depth
            assign prod = PROD_W'(r_val) * PROD_W'(RECIP);
            assign back = r_quo * DEP;

            // Phase count: 2 quotient, 1 remainder, 0 done
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_phase <= '0;
                end else if (i_start) begin
                    r_phase <= 2'd2;
                end else if (r_phase != '0) begin
                    r_phase <= r_phase - 2'd1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                end
                if (r_phase == 2'd2) begin
                    r_quo <= ahilp_pkg::HASH_W'(prod >> SHIFT);
                end
                if (r_phase == 2'd1) begin
                    r_rem <= AW'(r_val - back);
                end
            end

            assign o_done = (r_phase == '0);
            assign o_home = r_rem;
        end
    endgenerate

endmodule

@@ hw/rtl/address_hash_index_linear_probe.sv @@
// Linear-probing hash index keyed on a four-byte network address.
// Command port: a word is taken on a clock edge with start high and busy low.
// action selects clear (0), insert (1) or lookup (2); action 3 is dropped
// with no result. Each result is shown for one cycle with o_valid high and
// must be taken then; there is no back-pressure on the result side.
// Insert and lookup pass from the accepting edge through the hash, read and
// probe states; when TABLE_DEPTH is a power of two the home slot is the low
// bits of the last two address bytes, otherwise it comes from a two-stage
// reciprocal-multiply remainder. Each probe is one read of the slot memory.
// A lookup on an empty table and an insert into a full table answer on the
// next edge. busy falls as the result is shown, so the next word can be
// taken on the edge that takes the result. Clear sweeps the slot memory, one
// slot per cycle, then gives the cleared result. After reset the same sweep
// runs with busy high and no result.
module address_hash_index_linear_probe #(
    parameter int TABLE_DEPTH = ahilp_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_action,
    input  logic [7:0]                     i_addr_byte0,
    input  logic [7:0]                     i_addr_byte1,
    input  logic [7:0]                     i_addr_byte2,
    input  logic [7:0]                     i_addr_byte3,
    input  logic [ahilp_pkg::ENTRY_W-1:0]  i_entry_number,
    output logic                           o_valid,
    output logic [ahilp_pkg::STATUS_W-1:0] o_status,
    output logic [ahilp_pkg::ENTRY_W-1:0]  o_found_entry,
    output logic [ahilp_pkg::SLOT_W-1:0]   o_slot_used
);

    `include "address_hash_index_linear_probe_assert.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    ahilp_pkg::t_state r_state, n_state;

    logic [1:0]                     r_act, n_act;
    logic [ahilp_pkg::KEY_W-1:0]    r_key, n_key;
    logic [ahilp_pkg::ENTRY_W-1:0]  r_entry, n_entry;
    logic [AW-1:0]                  r_slot, n_slot;
    logic [CW-1:0]                  r_probe, n_probe;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_clr_rsp, n_clr_rsp;

    logic                           r_valid, n_valid;
    logic [ahilp_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ahilp_pkg::ENTRY_W-1:0]  r_found, n_found;
    logic [ahilp_pkg::SLOT_W-1:0]   r_slot_out, n_slot_out;

    logic                           hash_start;
    logic                           hash_done;
    logic [AW-1:0]                  hash_home;

    logic                           mem_we;
    logic [AW-1:0]                  mem_raddr;
    ahilp_pkg::t_slot               mem_wdata;
    ahilp_pkg::t_slot               mem_rdata;

    logic [AW-1:0]                  slot_nxt;
    logic [CW-1:0]                  probe_inc;

    // Home slot unit
    ahilp_hash #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_value ({i_addr_byte2, i_addr_byte3}),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    // Slot memory
    ahilp_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_slot),
        .i_wr_data (mem_wdata),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    // Probe step with wraparound
    assign slot_nxt  = (r_slot == AW'(TABLE_DEPTH - 1)) ? '0 : r_slot + AW'(1);
    assign probe_inc = r_probe + CW'(1);

    assign busy = (r_state != ahilp_pkg::S_IDLE);

    // Next state and datapath control
    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_key      = r_key;
        n_entry    = r_entry;
        n_slot     = r_slot;
        n_probe    = r_probe;
        n_count    = r_count;
        n_clr_rsp  = r_clr_rsp;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        n_slot_out = r_slot_out;
        hash_start = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        mem_raddr  = r_slot;

        case (r_state)
            ahilp_pkg::S_IDLE: begin
                if (start) begin
                    n_act   = i_action;
                    n_key   = {i_addr_byte0, i_addr_byte1, i_addr_byte2, i_addr_byte3};
                    n_entry = i_entry_number;
                    case (i_action)
                        ahilp_pkg::ACT_CLEAR: begin
                            n_slot    = '0;
                            n_count   = '0;
                            n_clr_rsp = 1'b1;
                            n_state   = ahilp_pkg::S_CLEAR;
                        end
                        ahilp_pkg::ACT_INSERT: begin
                            if (r_count == CW'(TABLE_DEPTH)) begin
                                // every slot taken: nothing to probe
                                n_valid    = 1'b1;
                                n_status   = ahilp_pkg::STAT_FULL;
                                n_found    = '0;
                                n_slot_out = '0;
                            end else begin
                                hash_start = 1'b1;
                                n_state    = ahilp_pkg::S_HASH;
                            end
                        end
                        ahilp_pkg::ACT_LOOKUP: begin
                            if (r_count == '0) begin
                                // empty table: no probe at all
                                n_valid    = 1'b1;
                                n_status   = ahilp_pkg::STAT_MISSING;
                                n_found    = '0;
                                n_slot_out = '0;
                            end else begin
                                hash_start = 1'b1;
                                n_state    = ahilp_pkg::S_HASH;
                            end
                        end
                        default: begin
                            // unused action: dropped
                        end
                    endcase
                end
            end

            ahilp_pkg::S_HASH: begin
                if (hash_done) begin
                    n_slot  = hash_home;
                    n_probe = '0;
                    n_state = ahilp_pkg::S_READ;
                end
            end

            ahilp_pkg::S_READ: begin
                n_state = ahilp_pkg::S_PROBE;
            end

            ahilp_pkg::S_PROBE: begin
                // mem_rdata holds the slot at r_slot
                n_found    = '0;
                n_slot_out = '0;
                if (r_act == ahilp_pkg::ACT_INSERT) begin
                    if (!mem_rdata.valid) begin
                        mem_we     = 1'b1;
                        mem_wdata  = '{valid: 1'b1, key: r_key, entry: r_entry};
                        n_count    = r_count + CW'(1);
                        n_valid    = 1'b1;
                        n_status   = ahilp_pkg::STAT_INSERTED;
                        n_slot_out = ahilp_pkg::SLOT_W'(r_slot);
                        n_state    = ahilp_pkg::S_IDLE;
                    end else if (probe_inc == CW'(TABLE_DEPTH)) begin
                        n_valid  = 1'b1;
                        n_status = ahilp_pkg::STAT_FULL;
                        n_state  = ahilp_pkg::S_IDLE;
                    end else begin
                        n_slot    = slot_nxt;
                        n_probe   = probe_inc;
                        mem_raddr = slot_nxt;
                    end
                end else begin
                    if (!mem_rdata.valid) begin
                        n_valid  = 1'b1;
                        n_status = ahilp_pkg::STAT_MISSING;
                        n_state  = ahilp_pkg::S_IDLE;
                    end else if (mem_rdata.key == r_key) begin
                        n_valid    = 1'b1;
                        n_status   = ahilp_pkg::STAT_FOUND;
                        n_found    = mem_rdata.entry;
                        n_slot_out = ahilp_pkg::SLOT_W'(r_slot);
                        n_state    = ahilp_pkg::S_IDLE;
                    end else if (probe_inc >= r_count) begin
                        // probe budget spent
                        n_valid  = 1'b1;
                        n_status = ahilp_pkg::STAT_MISSING;
                        n_state  = ahilp_pkg::S_IDLE;
                    end else begin
                        n_slot    = slot_nxt;
                        n_probe   = probe_inc;
                        mem_raddr = slot_nxt;
                    end
                end
            end

            ahilp_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_slot == AW'(TABLE_DEPTH - 1)) begin
                    n_state   = ahilp_pkg::S_IDLE;
                    n_clr_rsp = 1'b0;
                    if (r_clr_rsp) begin
                        n_valid    = 1'b1;
                        n_status   = ahilp_pkg::STAT_CLEARED;
                        n_found    = '0;
                        n_slot_out = '0;
                    end
                end else begin
                    n_slot = slot_nxt;
                end
            end

            default: begin
                n_state = ahilp_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ahilp_pkg::S_CLEAR;
            r_slot    <= '0;
            r_count   <= '0;
            r_clr_rsp <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_count   <= n_count;
            r_clr_rsp <= n_clr_rsp;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_entry    <= n_entry;
        r_probe    <= n_probe;
        r_status   <= n_status;
        r_found    <= n_found;
        r_slot_out <= n_slot_out;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_entry = r_found;
    assign o_slot_used   = r_slot_out;

    // Checks
    `AHILP_ASSERT_IMP(a_wr_state, i_clk, i_rst_n, mem_we,
        (r_state == ahilp_pkg::S_PROBE || r_state == ahilp_pkg::S_CLEAR),
        "slot write outside probe or clear")
    `AHILP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n,
        (mem_we && r_state == ahilp_pkg::S_PROBE), !mem_rdata.valid,
        "insert overwrote a full slot")
    `AHILP_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        (r_count <= CW'(TABLE_DEPTH)), "stored count beyond depth")
    `AHILP_ASSERT_NXT(a_count_inc, i_clk, i_rst_n,
        (mem_we && r_state == ahilp_pkg::S_PROBE),
        (r_count == $past(r_count) + CW'(1)), "count not bumped on insert")
    `AHILP_ASSERT_IMP(a_found_zero, i_clk, i_rst_n,
        (o_valid && o_status != ahilp_pkg::STAT_FOUND), (o_found_entry == '0),
        "entry returned without a match")

endmodule

@@ dv/tb_address_hash_index_linear_probe.sv @@
module tb_address_hash_index_linear_probe;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH  = ahilp_pkg::DEF_TABLE_DEPTH;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int          RANDOM_WORDS = 1740;
    localparam int          CHAIN_LEN    = 64;
    localparam int          CHAIN_HOME   = 100;
    localparam int          DRAIN_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    // home slots that random traffic piles onto to build long probe chains
    localparam int          HOT_SLOTS [6] = '{0, 16380, 4660, 8192, 12000, 700};

    typedef struct packed {
        logic [1:0]                    action;
        logic [7:0]                    byte0;
        logic [7:0]                    byte1;
        logic [7:0]                    byte2;
        logic [7:0]                    byte3;
        logic [ahilp_pkg::ENTRY_W-1:0] entry;
    } t_index_cmd;

    typedef struct packed {
        logic [ahilp_pkg::STATUS_W-1:0] status;
        logic [ahilp_pkg::ENTRY_W-1:0]  found_entry;
        logic [ahilp_pkg::SLOT_W-1:0]   slot_used;
    } t_index_result;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           start          = 1'b0;
    logic [1:0]                     i_action       = ahilp_pkg::ACT_CLEAR;
    logic [7:0]                     i_addr_byte0   = '0;
    logic [7:0]                     i_addr_byte1   = '0;
    logic [7:0]                     i_addr_byte2   = '0;
    logic [7:0]                     i_addr_byte3   = '0;
    logic [ahilp_pkg::ENTRY_W-1:0]  i_entry_number = '0;
    logic                           busy;
    logic                           o_valid;
    logic [ahilp_pkg::STATUS_W-1:0] o_status;
    logic [ahilp_pkg::ENTRY_W-1:0]  o_found_entry;
    logic [ahilp_pkg::SLOT_W-1:0]   o_slot_used;

    // Shadow copy of the slot table
    bit                            shadow_valid [TABLE_DEPTH];
    logic [ahilp_pkg::KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
    logic [ahilp_pkg::ENTRY_W-1:0] shadow_entry [TABLE_DEPTH];
    int unsigned                   shadow_count = 0;

    t_index_result                 pending_results [$];
    logic [ahilp_pkg::KEY_W-1:0]   stored_keys [$];
    int unsigned                   send_idle_pct = 22;
    int unsigned                   cycle_count   = 0;
    int                            error_count   = 0;

    address_hash_index_linear_probe #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_addr_byte0   (i_addr_byte0),
        .i_addr_byte1   (i_addr_byte1),
        .i_addr_byte2   (i_addr_byte2),
        .i_addr_byte3   (i_addr_byte3),
        .i_entry_number (i_entry_number),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_entry  (o_found_entry),
        .o_slot_used    (o_slot_used)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Apply one command to the shadow table; returns 0 when no result word follows
    function automatic bit predict_index_result(input t_index_cmd cmd,
                                                output t_index_result res);
        logic [ahilp_pkg::KEY_W-1:0] key;
        int unsigned                 slot;
        int unsigned                 probes;
        key  = {cmd.byte0, cmd.byte1, cmd.byte2, cmd.byte3};
        slot = {cmd.byte2, cmd.byte3} % TABLE_DEPTH;
        res  = '0;
        case (cmd.action)
            ahilp_pkg::ACT_CLEAR: begin
                foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
                shadow_count = 0;
                res.status   = ahilp_pkg::STAT_CLEARED;
            end
            ahilp_pkg::ACT_INSERT: begin
                // first empty slot from home, wrapping; nothing written when full
                res.status = ahilp_pkg::STAT_FULL;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!shadow_valid[slot]) begin
                        shadow_valid[slot] = 1'b1;
                        shadow_key[slot]   = key;
                        shadow_entry[slot] = cmd.entry;
                        if (shadow_count < TABLE_DEPTH)
                            shadow_count++;
                        res.status    = ahilp_pkg::STAT_INSERTED;
                        res.slot_used = ahilp_pkg::SLOT_W'(slot);
                        break;
                    end
                    slot = (slot + 1) % TABLE_DEPTH;
                end
            end
            ahilp_pkg::ACT_LOOKUP: begin
                // walk no further than the number of entries stored
                res.status = ahilp_pkg::STAT_MISSING;
                probes = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
                for (int unsigned i = 0; i < probes; i++) begin
                    if (!shadow_valid[slot])
                        break;
                    if (shadow_key[slot] == key) begin
                        res.status      = ahilp_pkg::STAT_FOUND;
                        res.found_entry = shadow_entry[slot];
                        res.slot_used   = ahilp_pkg::SLOT_W'(slot);
                        break;
                    end
                    slot = (slot + 1) % TABLE_DEPTH;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_index_cmd make_cmd(input logic [1:0] action,
                                            input logic [ahilp_pkg::KEY_W-1:0] key,
                                            input logic [ahilp_pkg::ENTRY_W-1:0] entry);
        t_index_cmd cmd;
        cmd.action = action;
        {cmd.byte0, cmd.byte1, cmd.byte2, cmd.byte3} = key;
        cmd.entry  = entry;
        return cmd;
    endfunction

    // Key source: 0 anywhere, 1 near a hot home slot (aliased), 2 already stored
    function automatic logic [ahilp_pkg::KEY_W-1:0] pick_key(input int unsigned source);
        logic [ahilp_pkg::SLOT_W-1:0] home;
        if (source == 2 && stored_keys.size() != 0)
            return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        if (source == 1) begin
            home = ahilp_pkg::SLOT_W'(HOT_SLOTS[$urandom_range(0, 5)] + $urandom_range(0, 3));
            return {16'($urandom()), 2'($urandom_range(0, 3)), home};
        end
        return $urandom();
    endfunction

    // Present one command word, hold it until taken, then log what it should give
    task automatic send_word(input t_index_cmd cmd);
        bit            free_now;
        bit            has_result;
        t_index_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= cmd.action;
        i_addr_byte0   <= cmd.byte0;
        i_addr_byte1   <= cmd.byte1;
        i_addr_byte2   <= cmd.byte2;
        i_addr_byte3   <= cmd.byte3;
        i_entry_number <= cmd.entry;
        // busy sampled mid-cycle, so the edge that takes the word is known
        do begin
            @(negedge i_clk);
            free_now = !busy;
            @(posedge i_clk);
        end while (!free_now);
        has_result = predict_index_result(cmd, res);
        if (has_result)
            pending_results.push_back(res);
        if (cmd.action == ahilp_pkg::ACT_CLEAR)
            stored_keys.delete();
        else if (cmd.action == ahilp_pkg::ACT_INSERT && res.status == ahilp_pkg::STAT_INSERTED)
            stored_keys.push_back({cmd.byte0, cmd.byte1, cmd.byte2, cmd.byte3});
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result words are stable across the cycle; compare at the falling edge
    always @(negedge i_clk) begin
        t_index_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("found_entry", 16'(want.found_entry), 16'(o_found_entry));
                check_field("slot_used", 16'(want.slot_used), 16'(o_slot_used));
            end
        end
    end

    task automatic test_empty_lookup();
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hC0A8_0001, 14'h3FFF));
    endtask

    // action 3 must leave the table alone and give no word back
    task automatic test_unused_action();
        send_word(make_cmd(ACT_UNUSED, 32'hFFFF_FFFF, 14'h3FFF));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 14'h0000));
    endtask

    task automatic test_field_extremes();
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h0000_0000, 14'h0000));
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'hFFFF_FFFF, 14'h3FFF));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h0000_0000, 14'h3FFF));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 14'h0000));
        // same home as the all-zero key, different upper bytes
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hFFFF_0000, 14'h0000));
    endtask

    // top slot and slot 0 already taken, so the chain wraps round
    task automatic test_wraparound();
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h0A00_3FFF, 14'h1555));
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h0B00_BFFF, 14'h2AAA));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h0B00_BFFF, 14'h0000));
    endtask

    task automatic test_duplicate_key();
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h7F00_1234, 14'h0001));
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h7F00_1234, 14'h0002));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h7F00_1234, 14'h0000));
    endtask

    task automatic test_clear();
        send_word(make_cmd(ahilp_pkg::ACT_CLEAR, 32'h5A5A_5A5A, 14'h2A2A));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h7F00_1234, 14'h0000));
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h7F00_1234, 14'h0003));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h7F00_1234, 14'h0000));
    endtask

    // A run of consecutive homes, then keys that must walk the whole run
    task automatic test_long_chain();
        send_word(make_cmd(ahilp_pkg::ACT_CLEAR, 32'h0000_0000, 14'h0000));
        for (int h = 0; h < CHAIN_LEN; h++)
            send_word(make_cmd(ahilp_pkg::ACT_INSERT,
                               {16'($urandom()), 2'($urandom_range(0, 3)),
                                ahilp_pkg::SLOT_W'(CHAIN_HOME + h)},
                               ahilp_pkg::ENTRY_W'($urandom())));
        // lands just past the run
        send_word(make_cmd(ahilp_pkg::ACT_INSERT, 32'h1234_0064, 14'h2BCD));
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'h1234_0064, 14'h0000));
        // absent key: probe budget runs out at the end of the run
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hDEAD_0064, 14'h0000));
        // home just before the run is empty
        send_word(make_cmd(ahilp_pkg::ACT_LOOKUP, 32'hDEAD_0063, 14'h0000));
        send_word(make_cmd(ahilp_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 14'h3FFF));
    endtask

    // Mostly inserts and lookups on clustered and stored keys, rare clears and junk
    task automatic test_random_traffic(input int words);
        int          sent;
        int unsigned pick;
        t_index_cmd  cmd;
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(0, 999);
            if (pick < 5)
                cmd = make_cmd(ahilp_pkg::ACT_CLEAR, $urandom(),
                               ahilp_pkg::ENTRY_W'($urandom()));
            else if (pick < 20)
                cmd = make_cmd(ACT_UNUSED, $urandom(), ahilp_pkg::ENTRY_W'($urandom()));
            else if (pick < 470)
                cmd = make_cmd(ahilp_pkg::ACT_INSERT, pick_key($urandom_range(0, 2)),
                               ahilp_pkg::ENTRY_W'($urandom()));
            else begin
                pick = $urandom_range(0, 9);
                cmd  = make_cmd(ahilp_pkg::ACT_LOOKUP,
                                pick_key(pick < 6 ? 2 : (pick < 8 ? 1 : 0)),
                                ahilp_pkg::ENTRY_W'($urandom()));
            end
            send_word(cmd);
            if (cmd.action != ACT_UNUSED)
                sent++;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_unused_action();
        test_field_extremes();
        test_wraparound();
        test_duplicate_key();
        test_clear();
        test_long_chain();

        send_idle_pct = 22;
        test_random_traffic(RANDOM_WORDS / 3);
        send_idle_pct = 62;
        test_random_traffic(RANDOM_WORDS / 3);
        send_idle_pct = 0;
        test_random_traffic(RANDOM_WORDS / 3);

        // drain; the cycle guard covers a result that never comes
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ahilp_pkg.sv
hw/rtl/ahilp_mem.sv
hw/rtl/ahilp_hash.sv
hw/rtl/address_hash_index_linear_probe.sv
dv/tb_address_hash_index_linear_probe.sv
